// ----- rtl/latency_histogram_stats_assert.svh -----
// assertion macros for the latency histogram monitor checker
`ifndef LATENCY_HISTOGRAM_STATS_ASSERT_SVH
`define LATENCY_HISTOGRAM_STATS_ASSERT_SVH

// same-cycle property, held off during reset
`define LHS_CHECK(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("lhs check failed");

// condition in one cycle implies a consequence in the next
`define LHS_CHECK_NEXT(lbl, ck, rs, cond, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond) |=> (cons)) \
    else $error("lhs sequence check failed");

`endif

// ----- rtl/lhs_pkg.sv -----
// ----------------------------------------------------------------------------
// lhs_pkg
// shared types and codes of the latency histogram monitor
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [2:0] CFG_BUCKET_WIDTH = 3'd0;
  localparam logic [2:0] CFG_SCALE_MULT   = 3'd1;
  localparam logic [2:0] CFG_SCALE_SHIFT  = 3'd2;
  localparam logic [2:0] CFG_SWAP_MASK    = 3'd3;
  localparam logic [2:0] CFG_SCALE_MASK   = 3'd4;

  localparam int MASK_TYPES = 6;

  typedef struct packed {
    logic [15:0] bucket_width;
    logic [15:0] scale_mult;
    logic [4:0]  scale_shift;
    logic [5:0]  swap_mask;
    logic [5:0]  scale_mask;
  } lhs_cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic        opcode;
    logic        bad_slot;
    logic [1:0]  thread_id;
    logic [2:0]  lat_kind;
    logic [31:0] lat_raw;
    logic        do_scale;
    logic [6:0]  bucket_index;
  } lhs_entry_t;

  typedef struct packed {
    logic [31:0] latency_value;
    logic [31:0] average_value;
    logic [31:0] maximum_value;
    logic [31:0] sample_total;
    logic [31:0] bucket_count;
    logic        new_maximum;
    logic        overflow_flag;
  } lhs_res_t;

endpackage

// ----- rtl/lhs_if.sv -----
// ----------------------------------------------------------------------------
// lhs channel interfaces
// request, result and register write channels
// ----------------------------------------------------------------------------
interface lhs_item_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [1:0]  thread_id;
  logic [2:0]  lat_kind;
  logic [31:0] start_stamp;
  logic [31:0] end_stamp;
  logic [6:0]  bucket_index;
  modport source (output valid, opcode, thread_id, lat_kind, start_stamp,
                  end_stamp, bucket_index, input ready);
  modport sink (input valid, opcode, thread_id, lat_kind, start_stamp,
                end_stamp, bucket_index, output ready);
endinterface

interface lhs_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] latency_value;
  logic [31:0] average_value;
  logic [31:0] maximum_value;
  logic [31:0] sample_total;
  logic [31:0] bucket_count;
  logic        new_maximum;
  logic        overflow_flag;
  modport source (output valid, latency_value, average_value, maximum_value,
                  sample_total, bucket_count, new_maximum, overflow_flag,
                  input ready);
  modport sink (input valid, latency_value, average_value, maximum_value,
                sample_total, bucket_count, new_maximum, overflow_flag,
                output ready);
endinterface

interface lhs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lhs_front.sv -----
// ----------------------------------------------------------------------------
// lhs_front
// accepts requests, checks the slot and forms the raw latency
// ----------------------------------------------------------------------------
module lhs_front import lhs_pkg::*; #(
  parameter int THREAD_SLOTS = 4,
  parameter int TYPE_COUNT   = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  lhs_cfg_t   cfg_regs,
  lhs_item_if.sink   item,
  output logic       push_valid,
  output lhs_entry_t push_data,
  input  logic       push_ready
);

  logic       full;
  lhs_entry_t ent;
  lhs_entry_t ent_next;
  logic       swap;

  assign item.ready = !full || push_ready;
  assign push_valid = full;
  assign push_data  = ent;

  always_comb begin
    swap = 1'b0;
    ent_next.do_scale = 1'b0;
    if (int'(item.lat_kind) < MASK_TYPES) begin
      swap = cfg_regs.swap_mask[item.lat_kind];
      ent_next.do_scale = cfg_regs.scale_mask[item.lat_kind];
    end
    ent_next.opcode       = item.opcode;
    ent_next.bad_slot     = (int'(item.thread_id) >= THREAD_SLOTS) ||
                            (int'(item.lat_kind) >= TYPE_COUNT);
    ent_next.thread_id    = item.thread_id;
    ent_next.lat_kind     = item.lat_kind;
    ent_next.lat_raw      = swap ? (item.start_stamp - item.end_stamp)
                                 : (item.end_stamp - item.start_stamp);
    ent_next.bucket_index = item.bucket_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item.valid && item.ready) begin
      full <= 1'b1;
    end else if (push_ready) begin
      full <= 1'b0;
    end
    if (item.valid && item.ready) begin
      ent <= ent_next;
    end
  end

endmodule

// ----- rtl/lhs_queue.sv -----
// ----------------------------------------------------------------------------
// lhs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module lhs_queue import lhs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  input  lhs_entry_t push_data,
  output logic       push_ready,
  output logic       pop_valid,
  output lhs_entry_t pop_data,
  input  logic       pop_ready
);

  lhs_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/lhs_back.sv -----
// ----------------------------------------------------------------------------
// lhs_back
// scaling, dividers, slot statistics, histogram memory and result register
// ----------------------------------------------------------------------------
module lhs_back import lhs_pkg::*; #(
  parameter int THREAD_SLOTS = 4,
  parameter int TYPE_COUNT   = 6,
  parameter int BUCKET_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  lhs_cfg_t    cfg_regs,
  input  logic        pop_valid,
  input  lhs_entry_t  pop_data,
  output logic        pop_ready,
  lhs_result_if.source result
);

  localparam int SLOTS  = THREAD_SLOTS * TYPE_COUNT;
  localparam int BINS   = BUCKET_COUNT + 1;
  localparam int DEPTH  = SLOTS * BINS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MUL, S_SCALE, S_PREP, S_DIV, S_ADDR, S_RADDR,
    S_RD, S_UPD, S_DONE
  } state_t;

  state_t      state;
  lhs_entry_t  ent;
  logic [SLOT_W-1:0] slot;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] clr_addr;
  logic [47:0] prod;
  logic [47:0] shifted;
  logic [31:0] lat;
  logic [63:0] sum_new;
  logic [31:0] cnt_new;
  logic        ovf;
  logic        clamp;
  logic        bidx_ok;
  logic [31:0] a_rem;
  logic [31:0] a_dvd;
  logic [31:0] a_quot;
  logic [15:0] b_rem;
  logic [31:0] b_dvd;
  logic [31:0] b_quot;
  logic [15:0] b_div;
  logic [4:0]  step;
  lhs_res_t    res;
  logic        out_valid;
  lhs_res_t    out_data;

  logic [63:0] sum_mem [SLOTS];
  logic [31:0] cnt_mem [SLOTS];
  logic [31:0] max_mem [SLOTS];
  logic [31:0] cur_mem [SLOTS];
  logic [31:0] avg_mem [SLOTS];

  logic [31:0] hist_mem [DEPTH];
  logic [31:0] hist_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  logic [64:0] sum_ext;
  logic [32:0] a_try;
  logic [32:0] a_diff;
  logic [16:0] b_try;
  logic [16:0] b_diff;
  logic [31:0] a_rem_next;
  logic [15:0] b_rem_next;
  logic [31:0] bin_sel;
  logic [31:0] slot_base;
  logic [SLOT_W-1:0] slot_next;

  assign pop_ready = (state == S_IDLE);

  always_comb begin
    shifted    = prod >> cfg_regs.scale_shift;
    sum_ext    = {1'b0, sum_mem[slot]} + {33'b0, lat};
    a_try      = {a_rem, a_dvd[31]};
    a_diff     = a_try - {1'b0, cnt_new};
    a_rem_next = a_diff[32] ? a_try[31:0] : a_diff[31:0];
    b_try      = {b_rem, b_dvd[31]};
    b_diff     = b_try - {1'b0, b_div};
    b_rem_next = b_diff[16] ? b_try[15:0] : b_diff[15:0];
    bin_sel    = (b_quot >= 32'(BUCKET_COUNT)) ? 32'(BUCKET_COUNT) : b_quot;
    slot_base  = 32'(int'(slot) * BINS);
    slot_next  = SLOT_W'(int'(pop_data.thread_id) * TYPE_COUNT +
                         int'(pop_data.lat_kind));
  end

  // histogram write port: clearing sweep or counter update
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = hist_q + 32'd1;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_UPD && ent.opcode == OP_RECORD && !ovf) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    hist_q <= hist_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        sum_mem[i] <= '0;
        cnt_mem[i] <= '0;
        max_mem[i] <= '0;
        cur_mem[i] <= '0;
        avg_mem[i] <= '0;
      end
    end else begin
      // output register loads in S_DONE, empties when taken
      if (state == S_DONE && (!out_valid || result.ready)) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop_valid) begin
            ent  <= pop_data;
            slot <= slot_next;
            if (pop_data.bad_slot) begin
              res   <= '0;
              state <= S_DONE;
            end else if (pop_data.opcode == OP_READ) begin
              state <= S_RADDR;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= {16'b0, ent.lat_raw} * {32'b0, cfg_regs.scale_mult};
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (ent.do_scale) begin
            lat <= (|shifted[47:32]) ? '1 : shifted[31:0];
          end else begin
            lat <= ent.lat_raw;
          end
          state <= S_PREP;
        end
        S_PREP: begin
          ovf     <= (sum_ext >= 65'h0_FFFF_FFFF_FFFF_FFFF);
          sum_new <= sum_ext[63:0];
          cnt_new <= (cnt_mem[slot] == '1) ? cnt_mem[slot] : cnt_mem[slot] + 32'd1;
          a_dvd   <= sum_ext[31:0];
          b_rem   <= '0;
          b_dvd   <= lat;
          b_div   <= (cfg_regs.bucket_width == '0) ? 16'd1 : cfg_regs.bucket_width;
          step    <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (step == 5'd0) begin
            // first step also sets the high half as the starting remainder
            clamp <= (sum_new[63:32] >= cnt_new);
          end
          a_rem  <= (step == 5'd0) ? sum_new[63:32] : a_rem_next;
          a_dvd  <= (step == 5'd0) ? a_dvd : {a_dvd[30:0], 1'b0};
          a_quot <= (step == 5'd0) ? a_quot : {a_quot[30:0], !a_diff[32]};
          b_rem  <= b_rem_next;
          b_dvd  <= {b_dvd[30:0], 1'b0};
          b_quot <= {b_quot[30:0], !b_diff[16]};
          step   <= step + 5'd1;
          if (step == 5'd31) state <= S_ADDR;
        end
        S_ADDR: begin
          // last average quotient bit
          a_quot <= {a_quot[30:0], !a_diff[32]};
          addr   <= ADDR_W'(slot_base + bin_sel);
          state  <= S_RD;
        end
        S_RADDR: begin
          bidx_ok <= (int'(ent.bucket_index) <= BUCKET_COUNT);
          if (int'(ent.bucket_index) <= BUCKET_COUNT) begin
            addr <= ADDR_W'(slot_base + 32'(ent.bucket_index));
          end else begin
            addr <= ADDR_W'(slot_base);
          end
          state <= S_RD;
        end
        S_RD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (ent.opcode == OP_READ) begin
            res.latency_value <= cur_mem[slot];
            res.average_value <= avg_mem[slot];
            res.maximum_value <= max_mem[slot];
            res.sample_total  <= cnt_mem[slot];
            res.bucket_count  <= bidx_ok ? hist_q : '0;
            res.new_maximum   <= 1'b0;
            res.overflow_flag <= 1'b0;
          end else if (ovf) begin
            res.latency_value <= lat;
            res.average_value <= avg_mem[slot];
            res.maximum_value <= max_mem[slot];
            res.sample_total  <= cnt_mem[slot];
            res.bucket_count  <= hist_q;
            res.new_maximum   <= 1'b0;
            res.overflow_flag <= 1'b1;
          end else begin
            sum_mem[slot] <= sum_new;
            cnt_mem[slot] <= cnt_new;
            avg_mem[slot] <= clamp ? '1 : a_quot;
            cur_mem[slot] <= lat;
            res.latency_value <= lat;
            res.average_value <= clamp ? '1 : a_quot;
            res.sample_total  <= cnt_new;
            res.bucket_count  <= hist_q + 32'd1;
            res.overflow_flag <= 1'b0;
            if (lat > max_mem[slot]) begin
              max_mem[slot]     <= lat;
              res.maximum_value <= lat;
              res.new_maximum   <= 1'b1;
            end else begin
              res.maximum_value <= max_mem[slot];
              res.new_maximum   <= 1'b0;
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.latency_value = out_data.latency_value;
  assign result.average_value = out_data.average_value;
  assign result.maximum_value = out_data.maximum_value;
  assign result.sample_total  = out_data.sample_total;
  assign result.bucket_count  = out_data.bucket_count;
  assign result.new_maximum   = out_data.new_maximum;
  assign result.overflow_flag = out_data.overflow_flag;

endmodule

// ----- rtl/latency_histogram_stats.sv -----
// ----------------------------------------------------------------------------
// latency_histogram_stats
// per thread and latency type statistics with a latency histogram
// ----------------------------------------------------------------------------
// usage
// - item channel: a record request turns two timer stamps into a latency and
//   folds it into the slot's total, average, maximum and histogram; a read
//   request returns one bucket and the slot's statistics
// - result channel: exactly one result per request, in request order
// - cfg channel: register writes, always ready; write only while idle
// - a record passes through the back end in order: multiply, scale, the shared
//   bit-serial step (average quotient and bucket quotient side by side),
//   histogram read and write; a read skips the arithmetic
// - the back end takes the next request from the queue only once it is idle again
// - the front register and a two-entry queue take up to three more requests
//   while the back end works
// - after reset the histogram memory is swept to zero, one entry a cycle, all
//   THREAD_SLOTS * TYPE_COUNT * (BUCKET_COUNT + 1) entries (1560 by default);
//   no request is taken from the queue until then, register writes are taken
// - a stalled result holds in the output register; the back end waits, the
//   queue fills and then item.ready drops
// ----------------------------------------------------------------------------
module latency_histogram_stats import lhs_pkg::*; #(
  parameter int THREAD_SLOTS = 4,
  parameter int TYPE_COUNT   = 6,
  parameter int BUCKET_COUNT = 64
) (
  input  logic         clk,
  input  logic         rst,
  lhs_item_if.sink     item,
  lhs_result_if.source result,
  lhs_cfg_if.sink      cfg
);

  // configuration registers
  lhs_cfg_t cfg_regs;

  // front to queue
  logic       push_valid;
  logic       push_ready;
  lhs_entry_t push_data;

  // queue to back
  logic       pop_valid;
  logic       pop_ready;
  lhs_entry_t pop_data;

  assign cfg.ready = 1'b1;

  // register write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.bucket_width <= 16'd10;
      cfg_regs.scale_mult   <= 16'd1;
      cfg_regs.scale_shift  <= 5'd0;
      cfg_regs.swap_mask    <= 6'd48;
      cfg_regs.scale_mask   <= 6'd15;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_BUCKET_WIDTH: cfg_regs.bucket_width <= cfg.data;
        CFG_SCALE_MULT:   cfg_regs.scale_mult   <= cfg.data;
        CFG_SCALE_SHIFT:  cfg_regs.scale_shift  <= cfg.data[4:0];
        CFG_SWAP_MASK:    cfg_regs.swap_mask    <= cfg.data[5:0];
        CFG_SCALE_MASK:   cfg_regs.scale_mask   <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // front: slot check, stamp swap and raw difference
  lhs_front #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .TYPE_COUNT  (TYPE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_regs  (cfg_regs),
    .item      (item),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_ready(push_ready)
  );

  // decouples the front from the long back end
  lhs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_data (push_data),
    .push_ready(push_ready),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready)
  );

  // back: scaling, division, statistics and histogram update
  lhs_back #(
    .THREAD_SLOTS(THREAD_SLOTS),
    .TYPE_COUNT  (TYPE_COUNT),
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .pop_valid(pop_valid),
    .pop_data (pop_data),
    .pop_ready(pop_ready),
    .result   (result)
  );

endmodule

// ----- rtl/lhs_checker.sv -----
// ----------------------------------------------------------------------------
// lhs_checker
// port-level checks on the result channel of the latency monitor
// ----------------------------------------------------------------------------
`include "latency_histogram_stats_assert.svh"

module lhs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_latency,
  input logic [31:0] out_maximum,
  input logic [31:0] out_total,
  input logic        out_new_max,
  input logic        out_ovf
);

  // stalled result stays put
  `LHS_CHECK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_latency))

  // a discarded sample never raises the maximum
  `LHS_CHECK(a_flags, clk, rst, out_valid |-> !(out_new_max && out_ovf))

  // a new maximum is the reported latency of a counted sample
  `LHS_CHECK(a_newmax, clk, rst, out_valid && out_new_max |-> out_latency == out_maximum && out_total != 0)

  // overflow needs a nonzero latency and an existing total
  `LHS_CHECK(a_ovf, clk, rst, out_valid && out_ovf |-> out_latency != 0 && out_total != 0)

endmodule

bind latency_histogram_stats lhs_checker u_lhs_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_latency(result.latency_value),
  .out_maximum(result.maximum_value),
  .out_total  (result.sample_total),
  .out_new_max(result.new_maximum),
  .out_ovf    (result.overflow_flag)
);
